// ----- sv/bamm_pkg.sv -----
// shared types, constants and reset values for the battery and mains monitor
package bamm_pkg;

  // default build parameters
  localparam int AVG_SAMPLES_LOG2_DEF = 4;
  localparam int ADC_BITS_DEF         = 12;

  // field and register widths
  localparam int MV_W       = 13;
  localparam int THR_W      = 13;
  localparam int TMO_W      = 16;
  localparam int BS_W       = 3;
  localparam int MS_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // millivolt scaling: mv = (11*mean + 5) / 10 = mean + (mean + 5) / 10
  localparam int MV_ROUND = 5;
  // floor(x / 10) = (x * 52429) >> 19, exact for x below 2^18
  localparam int RECIP_MUL   = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam logic [MV_W-1:0] MV_MAX = 13'd8191;

  // register reset values
  localparam logic [THR_W-1:0] THR_CHARGE_END_RST = 13'd2720;
  localparam logic [THR_W-1:0] THR_BLINK_RST      = 13'd2100;
  localparam logic [THR_W-1:0] THR_ATTENTION_RST  = 13'd1850;
  localparam logic [THR_W-1:0] THR_ABSENT_RST     = 13'd1500;
  localparam logic [TMO_W-1:0] MAINS_TIMEOUT_RST  = 16'd1000;

  typedef enum logic [BS_W-1:0] {
    BS_OFF, BS_NONE, BS_DEEP, BS_ATTENTION, BS_BLINK, BS_CHARGE_END
  } bat_state_t;

  typedef enum logic [MS_W-1:0] {
    MS_OFF, MS_OK, MS_LOST
  } mains_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAT_EN, CFG_MAINS_EN, CFG_THR_CHARGE_END, CFG_THR_BLINK,
    CFG_THR_ATTENTION, CFG_THR_ABSENT, CFG_MAINS_TIMEOUT
  } cfg_idx_t;

  typedef struct packed {
    logic             bat_en;
    logic             mains_en;
    logic [THR_W-1:0] thr_charge_end;
    logic [THR_W-1:0] thr_blink;
    logic [THR_W-1:0] thr_attention;
    logic [THR_W-1:0] thr_absent;
    logic [TMO_W-1:0] mains_timeout;
  } cfg_t;

  // control that travels with each request down the pipeline
  typedef struct packed {
    logic         valid;
    logic         updated;
    mains_state_t mains;
  } stage_ctl_t;

endpackage

// ----- sv/bamm_ifs.sv -----
// valid/ready channel interfaces for the monitor input and result streams
interface bamm_in_if #(
  parameter int ADC_BITS = bamm_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] bat_sample;
  logic                mains_pin_low;

  modport source (output valid, bat_sample, mains_pin_low, input ready);
  modport sink   (input valid, bat_sample, mains_pin_low, output ready);
endinterface

interface bamm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bamm_pkg::MV_W-1:0] bat_millivolts;
  logic [bamm_pkg::BS_W-1:0] bat_status;
  logic [bamm_pkg::MS_W-1:0] mains_status;
  logic                      bat_updated;

  modport source (output valid, bat_millivolts, bat_status, mains_status, bat_updated,
                  input ready);
  modport sink   (input valid, bat_millivolts, bat_status, mains_status, bat_updated,
                  output ready);
endinterface

// ----- sv/bamm_front.sv -----
// sample accumulator, block counter and mains watchdog, first pipeline stage
module bamm_front #(
  parameter int AVG_SAMPLES_LOG2 = bamm_pkg::AVG_SAMPLES_LOG2_DEF,
  parameter int ADC_BITS         = bamm_pkg::ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 fire,
  input  logic [ADC_BITS-1:0]  sample,
  input  logic                 pin_low,
  input  bamm_pkg::cfg_t       cfg,
  output bamm_pkg::stage_ctl_t ctl_o,
  output logic [ADC_BITS-1:0]  mean_o
);
  import bamm_pkg::*;

  localparam int SUM_W = ADC_BITS + AVG_SAMPLES_LOG2;
  localparam int CNT_W = AVG_SAMPLES_LOG2 + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVG_SAMPLES_LOG2) - 1);

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done;
  logic [TMO_W-1:0] tick_r, tick_nxt, tick_base, tick_inc;
  logic             lost;
  mains_state_t     ms_r, ms_nxt, ms_calc;

  logic                v1_r;
  logic                upd1_r;
  mains_state_t        ms1_r;
  logic [ADC_BITS-1:0] mean1_r;

  // block accumulation
  always_comb begin
    sum_add = sum_r + SUM_W'(sample);
    done    = (cnt_r == CNT_LAST);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (done) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // mains watchdog: cleared by pin, lost at timeout, forced off when disabled
  always_comb begin
    tick_base = pin_low ? '0 : tick_r;
    tick_inc  = tick_base + TMO_W'(1);
    lost      = (tick_inc >= cfg.mains_timeout);
    if (lost) begin
      ms_calc = MS_LOST;
    end else if (pin_low) begin
      ms_calc = MS_OK;
    end else begin
      ms_calc = ms_r;
    end
    tick_nxt = tick_r;
    ms_nxt   = ms_r;
    if (fire) begin
      tick_nxt = lost ? '0 : tick_inc;
      ms_nxt   = cfg.mains_en ? ms_calc : MS_OFF;
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      tick_r <= '0;
      ms_r   <= MS_OFF;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      tick_r <= tick_nxt;
      ms_r   <= ms_nxt;
    end
  end

  // stage register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (advance) begin
      v1_r <= fire;
    end
  end

  // stage register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      upd1_r  <= done;
      ms1_r   <= ms_nxt;
      mean1_r <= sum_add[SUM_W-1:AVG_SAMPLES_LOG2];
    end
  end

  assign ctl_o.valid   = v1_r;
  assign ctl_o.updated = upd1_r;
  assign ctl_o.mains   = ms1_r;
  assign mean_o        = mean1_r;

endmodule

// ----- sv/bamm_scale.sv -----
// rounded divide by ten of the block mean by reciprocal multiply, second stage
module bamm_scale #(
  parameter int ADC_BITS = bamm_pkg::ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  bamm_pkg::stage_ctl_t ctl_i,
  input  logic [ADC_BITS-1:0]  mean_i,
  output bamm_pkg::stage_ctl_t ctl_o,
  output logic [ADC_BITS-1:0]  mean_o,
  output logic [ADC_BITS-1:0]  quot_o
);
  import bamm_pkg::*;

  localparam int PROD_W = ADC_BITS + RECIP_SHIFT;

  logic [PROD_W-1:0]   rounded;
  logic [PROD_W-1:0]   prod;
  logic [ADC_BITS-1:0] quot;

  logic                v2_r;
  logic                upd2_r;
  mains_state_t        ms2_r;
  logic [ADC_BITS-1:0] mean2_r;
  logic [ADC_BITS-1:0] quot2_r;

  // (mean + 5) / 10
  always_comb begin
    rounded = PROD_W'(mean_i) + PROD_W'(MV_ROUND);
    prod    = rounded * PROD_W'(RECIP_MUL);
    quot    = prod[PROD_W-1 -: ADC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl_i.valid) begin
      upd2_r  <= ctl_i.updated;
      ms2_r   <= ctl_i.mains;
      mean2_r <= mean_i;
      quot2_r <= quot;
    end
  end

  assign ctl_o.valid   = v2_r;
  assign ctl_o.updated = upd2_r;
  assign ctl_o.mains   = ms2_r;
  assign mean_o        = mean2_r;
  assign quot_o        = quot2_r;

endmodule

// ----- sv/bamm_class.sv -----
// millivolt saturation, threshold classification and result register
module bamm_class #(
  parameter int ADC_BITS = bamm_pkg::ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  bamm_pkg::stage_ctl_t ctl_i,
  input  logic [ADC_BITS-1:0]  mean_i,
  input  logic [ADC_BITS-1:0]  quot_i,
  input  bamm_pkg::cfg_t       cfg,
  bamm_out_if.source           out_ch
);
  import bamm_pkg::*;

  localparam int EXT_W = (ADC_BITS + 1 > MV_W) ? ADC_BITS + 1 : MV_W + 1;

  logic [EXT_W-1:0] mv_ext;
  logic [MV_W-1:0]  mv_sat;
  bat_state_t       bs_calc;

  logic [MV_W-1:0]  mv_r, mv_nxt;
  bat_state_t       bs_r, bs_nxt;

  logic             out_valid_r;
  logic [MV_W-1:0]  out_mv_r;
  bat_state_t       out_bs_r;
  mains_state_t     out_ms_r;
  logic             out_upd_r;

  // mean + quotient, clipped to the millivolt range
  always_comb begin
    mv_ext = EXT_W'(mean_i) + EXT_W'(quot_i);
    if (mv_ext > EXT_W'(MV_MAX)) begin
      mv_sat = MV_MAX;
    end else begin
      mv_sat = mv_ext[MV_W-1:0];
    end
  end

  // threshold ladder, first match wins; a value equal to blink falls through to the attention test
  always_comb begin
    if (!cfg.bat_en) begin
      bs_calc = BS_OFF;
    end else if (mv_sat > cfg.thr_charge_end) begin
      bs_calc = BS_CHARGE_END;
    end else if (mv_sat > cfg.thr_blink) begin
      bs_calc = BS_BLINK;
    end else if (mv_sat > cfg.thr_attention) begin
      bs_calc = BS_ATTENTION;
    end else if (mv_sat < cfg.thr_absent) begin
      bs_calc = BS_NONE;
    end else begin
      bs_calc = BS_DEEP;
    end
  end

  // held battery value changes only when a block completes
  always_comb begin
    mv_nxt = mv_r;
    bs_nxt = bs_r;
    if (ctl_i.valid && ctl_i.updated) begin
      mv_nxt = mv_sat;
      bs_nxt = bs_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r        <= '0;
      bs_r        <= BS_OFF;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      mv_r        <= mv_nxt;
      bs_r        <= bs_nxt;
      out_valid_r <= ctl_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && ctl_i.valid) begin
      out_mv_r  <= mv_nxt;
      out_bs_r  <= bs_nxt;
      out_ms_r  <= ctl_i.mains;
      out_upd_r <= ctl_i.updated;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bat_millivolts = out_mv_r;
  assign out_ch.bat_status     = out_bs_r;
  assign out_ch.mains_status   = out_ms_r;
  assign out_ch.bat_updated    = out_upd_r;

endmodule

// ----- sv/battery_and_mains_monitor.sv -----
// top level of the battery and mains monitor: config registers and pipeline
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        bat_sample, mains_pin_low
//   out_ch    out  valid/ready        bat_millivolts, bat_status, mains_status, bat_updated
//   cfg_*     in   cfg_we, no ready   cfg_idx, cfg_wdata
//
// one request per cycle while results are taken; a result is presented once its request reaches the result register
// the request is loaded into the first of three register stages at its accepting edge:
// accumulator and watchdog, reciprocal multiply for the divide by ten, classifier and
// result register
// synchronous reset clears the pipeline and state, and restores register defaults
// when a result is not taken every stage holds and in_ch.ready drops
module battery_and_mains_monitor #(
  parameter int AVG_SAMPLES_LOG2 = bamm_pkg::AVG_SAMPLES_LOG2_DEF,
  parameter int ADC_BITS         = bamm_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bamm_in_if.sink                         in_ch,
  bamm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bamm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bamm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bamm_pkg::*;

  cfg_t                cfg_r;
  logic                advance;
  logic                fire;
  stage_ctl_t          ctl1, ctl2;
  logic [ADC_BITS-1:0] mean1, mean2, quot2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bat_en         <= 1'b1;
      cfg_r.mains_en       <= 1'b1;
      cfg_r.thr_charge_end <= THR_CHARGE_END_RST;
      cfg_r.thr_blink      <= THR_BLINK_RST;
      cfg_r.thr_attention  <= THR_ATTENTION_RST;
      cfg_r.thr_absent     <= THR_ABSENT_RST;
      cfg_r.mains_timeout  <= MAINS_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_BAT_EN:         cfg_r.bat_en         <= cfg_wdata[0];
        CFG_MAINS_EN:       cfg_r.mains_en       <= cfg_wdata[0];
        CFG_THR_CHARGE_END: cfg_r.thr_charge_end <= cfg_wdata[THR_W-1:0];
        CFG_THR_BLINK:      cfg_r.thr_blink      <= cfg_wdata[THR_W-1:0];
        CFG_THR_ATTENTION:  cfg_r.thr_attention  <= cfg_wdata[THR_W-1:0];
        CFG_THR_ABSENT:     cfg_r.thr_absent     <= cfg_wdata[THR_W-1:0];
        CFG_MAINS_TIMEOUT:  cfg_r.mains_timeout  <= cfg_wdata[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // whole pipeline moves whenever the result register is free or being taken
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign fire        = in_ch.valid && advance;

  bamm_front #(
    .AVG_SAMPLES_LOG2 (AVG_SAMPLES_LOG2),
    .ADC_BITS         (ADC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .fire    (fire),
    .sample  (in_ch.bat_sample),
    .pin_low (in_ch.mains_pin_low),
    .cfg     (cfg_r),
    .ctl_o   (ctl1),
    .mean_o  (mean1)
  );

  bamm_scale #(
    .ADC_BITS (ADC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctl_i   (ctl1),
    .mean_i  (mean1),
    .ctl_o   (ctl2),
    .mean_o  (mean2),
    .quot_o  (quot2)
  );

  bamm_class #(
    .ADC_BITS (ADC_BITS)
  ) u_class (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctl_i   (ctl2),
    .mean_i  (mean2),
    .quot_i  (quot2),
    .cfg     (cfg_r),
    .out_ch  (out_ch)
  );

  // every accepted request shows up in the first stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ctl1.valid)
    else $error("accepted request missing from first stage");

  // a moving first stage lands in the second
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl1.valid && advance) |=> ctl2.valid)
    else $error("request lost between first and second stage");

  // the result valid follows the second stage valid whenever the pipeline moves
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_ch.valid == $past(ctl2.valid)))
    else $error("result valid does not follow second stage");

endmodule

// ----- tb/tb_top.sv -----
// testbench for the battery and mains monitor: directed and random ticks checked against a predictor
module tb_top;
  import bamm_pkg::*;

  localparam int AVG_LOG2 = AVG_SAMPLES_LOG2_DEF;
  localparam int ADC_W = ADC_BITS_DEF;
  localparam int BLOCK_LEN = 1 << AVG_LOG2;
  localparam int ADC_MAX = (1 << ADC_W) - 1;
  localparam int THR_MAX = (1 << THR_W) - 1;
  localparam int TMO_MAX = (1 << TMO_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int PIPE_LATENCY = 3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int ITEMS_TARGET = 1550;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    bat_state_t      bat;
    mains_state_t    mains;
    logic            updated;
  } tick_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bamm_in_if #(.ADC_BITS(ADC_W)) in_ch ();
  bamm_out_if out_ch ();

  battery_and_mains_monitor #(
    .AVG_SAMPLES_LOG2(AVG_LOG2),
    .ADC_BITS(ADC_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the settings
  logic bat_en_q;
  logic mains_en_q;
  logic [THR_W-1:0] thr_end_q;
  logic [THR_W-1:0] thr_blink_q;
  logic [THR_W-1:0] thr_attn_q;
  logic [THR_W-1:0] thr_absent_q;
  logic [TMO_W-1:0] timeout_q;

  // predictor copy of the monitor state
  logic [15:0] acc_sum;
  int acc_cnt;
  logic [TMO_W-1:0] watchdog_cnt;
  logic [MV_W-1:0] mv_q;
  bat_state_t bat_q;
  mains_state_t mains_q;

  tick_result_t pending_ticks[$];
  int faults;
  int items_sent;
  logic steady;

  function automatic int scale_mv(int mean);
    return (mean * 11 + MV_ROUND) / 10;
  endfunction

  function automatic void report_fault(string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(int value, int width);
    return CFG_DATA_W'(($urandom() << width) | value);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // check results, track settings, predict each accepted request
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    tick_result_t next;
    int mean_v;
    int scaled;
    if (!rst_n) begin
      bat_en_q = 1'b1;
      mains_en_q = 1'b1;
      thr_end_q = THR_CHARGE_END_RST;
      thr_blink_q = THR_BLINK_RST;
      thr_attn_q = THR_ATTENTION_RST;
      thr_absent_q = THR_ABSENT_RST;
      timeout_q = MAINS_TIMEOUT_RST;
      acc_sum = '0;
      acc_cnt = 0;
      watchdog_cnt = '0;
      mv_q = '0;
      bat_q = BS_OFF;
      mains_q = MS_OFF;
    end else begin
      // compare the result against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.mv = out_ch.bat_millivolts;
        got.bat = bat_state_t'(out_ch.bat_status);
        got.mains = mains_state_t'(out_ch.mains_status);
        got.updated = out_ch.bat_updated;
        if (pending_ticks.size() == 0) begin
          report_fault($sformatf("unexpected result mv=%0d bat=%0d mains=%0d upd=%0b",
                                 got.mv, got.bat, got.mains, got.updated));
        end else begin
          want = pending_ticks.pop_front();
          if (got.mv !== want.mv || got.bat !== want.bat || got.mains !== want.mains ||
              got.updated !== want.updated) begin
            report_fault($sformatf(
              {"mismatch: expected mv=%0d bat=%0d mains=%0d upd=%0b, ",
               "got mv=%0d bat=%0d mains=%0d upd=%0b"},
              want.mv, want.bat, want.mains, want.updated,
              got.mv, got.bat, got.mains, got.updated));
          end
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BAT_EN:         bat_en_q = cfg_wdata[0];
          CFG_MAINS_EN:       mains_en_q = cfg_wdata[0];
          CFG_THR_CHARGE_END: thr_end_q = cfg_wdata[THR_W-1:0];
          CFG_THR_BLINK:      thr_blink_q = cfg_wdata[THR_W-1:0];
          CFG_THR_ATTENTION:  thr_attn_q = cfg_wdata[THR_W-1:0];
          CFG_THR_ABSENT:     thr_absent_q = cfg_wdata[THR_W-1:0];
          CFG_MAINS_TIMEOUT:  timeout_q = cfg_wdata[TMO_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        // block average, scaling and battery grading
        next.updated = 1'b0;
        acc_sum = acc_sum + 16'(in_ch.bat_sample);
        acc_cnt++;
        if (acc_cnt == BLOCK_LEN) begin
          mean_v = int'(acc_sum >> AVG_LOG2);
          scaled = scale_mv(mean_v);
          if (scaled > int'(MV_MAX)) scaled = int'(MV_MAX);
          mv_q = MV_W'(scaled);
          if (!bat_en_q) bat_q = BS_OFF;
          else if (mv_q > thr_end_q) bat_q = BS_CHARGE_END;
          else if (mv_q > thr_blink_q) bat_q = BS_BLINK;
          else if (mv_q > thr_attn_q) bat_q = BS_ATTENTION;
          else if (mv_q < thr_absent_q) bat_q = BS_NONE;
          else if (mv_q <= thr_attn_q) bat_q = BS_DEEP;
          else bat_q = BS_NONE;
          acc_sum = '0;
          acc_cnt = 0;
          next.updated = 1'b1;
        end

        // mains watchdog
        if (in_ch.mains_pin_low) begin
          watchdog_cnt = '0;
          mains_q = MS_OK;
        end
        watchdog_cnt = watchdog_cnt + 1'b1;
        if (watchdog_cnt >= timeout_q) begin
          watchdog_cnt = '0;
          mains_q = MS_LOST;
        end
        if (!mains_en_q) mains_q = MS_OFF;

        next.mv = mv_q;
        next.bat = bat_q;
        next.mains = mains_q;
        pending_ticks.push_back(next);
      end
    end
  end

  // send one tick request; valid stays high until the next idle or drain
  task automatic send_tick(logic [ADC_W-1:0] sample, logic pin_low);
    while (!steady && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.bat_sample <= sample;
    in_ch.mains_pin_low <= pin_low;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // one averaging block whose mean is exactly the given value
  task automatic send_block(int mean, int pin_pct);
    int vals[$];
    int spread;
    int k;
    int extra;
    for (int i = 0; i < BLOCK_LEN; i += 2) begin
      spread = $urandom_range(mean < ADC_MAX - mean ? mean : ADC_MAX - mean);
      vals.push_back(mean + spread);
      vals.push_back(mean - spread);
    end
    vals.shuffle();
    // a remainder below the block length leaves the mean unchanged
    k = $urandom_range(BLOCK_LEN - 1);
    extra = $urandom_range(BLOCK_LEN - 1);
    if (vals[k] + extra <= ADC_MAX) vals[k] += extra;
    foreach (vals[i]) send_tick(ADC_W'(vals[i]), $urandom_range(99) < pin_pct);
  endtask

  // register write, then a wait with the enable low so it drops between writes
  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    // wait for a clock edge so the last accepted request is already predicted
    @(posedge clk);
    while (pending_ticks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // full-scale block at reset settings, mains present
  task automatic test_full_scale();
    send_block(ADC_MAX, 100);
    drain();
  endtask

  // watchdog with timeout zero and one, then with monitoring disabled
  task automatic test_watchdog_edges();
    write_setting(CFG_MAINS_TIMEOUT, '0);
    send_tick('0, 1'b1);
    send_tick('0, 1'b0);
    send_tick('0, 1'b0);
    drain();
    write_setting(CFG_MAINS_TIMEOUT, 16'd1);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    send_tick('0, 1'b0);
    drain();
    write_setting(CFG_MAINS_EN, '0);
    send_tick('0, 1'b1);
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    drain();
    write_setting(CFG_MAINS_EN, 16'd1);
    write_setting(CFG_MAINS_TIMEOUT, MAINS_TIMEOUT_RST);
  endtask

  // phases of random settings, mostly blocks aimed at the thresholds
  task automatic test_random_phases();
    int anchors[4];
    int thr[4];
    int pin_choices[5];
    int pin_pct;
    int mean;
    int tmo;
    pin_choices = '{0, 3, 30, 70, 100};
    // realign to a block boundary
    repeat ((BLOCK_LEN - acc_cnt) % BLOCK_LEN) begin
      send_tick(ADC_W'($urandom_range(ADC_MAX)), 1'($urandom_range(1)));
    end
    drain();
    while (items_sent < ITEMS_TARGET) begin
      steady = (items_sent >= 600 && items_sent < 900);
      foreach (anchors[k]) anchors[k] = $urandom_range(ADC_MAX);
      foreach (thr[k]) begin
        case ($urandom_range(9))
          0: thr[k] = 0;
          1: thr[k] = THR_MAX;
          default: begin
            thr[k] = scale_mv(anchors[k]) + $urandom_range(2) - 1;
            if (thr[k] < 0) thr[k] = 0;
          end
        endcase
      end
      // mostly ordered thresholds, sometimes out of order
      if ($urandom_range(9) < 7) thr.sort();
      write_setting(CFG_THR_CHARGE_END, with_junk(thr[3], THR_W));
      write_setting(CFG_THR_BLINK, with_junk(thr[2], THR_W));
      write_setting(CFG_THR_ATTENTION, with_junk(thr[1], THR_W));
      write_setting(CFG_THR_ABSENT, with_junk(thr[0], THR_W));
      write_setting(CFG_BAT_EN, with_junk($urandom_range(4) != 0, 1));
      write_setting(CFG_MAINS_EN, with_junk($urandom_range(4) != 0, 1));
      case ($urandom_range(9))
        0: tmo = 0;
        1: tmo = 1;
        2: tmo = TMO_MAX;
        3: tmo = int'(MAINS_TIMEOUT_RST);
        default: tmo = $urandom_range(60, 2);
      endcase
      write_setting(CFG_MAINS_TIMEOUT, CFG_DATA_W'(tmo));
      if ($urandom_range(4) == 0) write_setting(CFG_SPARE_IDX, CFG_DATA_W'($urandom()));
      pin_pct = pin_choices[$urandom_range(4)];

      repeat ($urandom_range(8, 3)) begin
        if ($urandom_range(6) == 0) begin
          // noise block
          repeat (BLOCK_LEN) begin
            send_tick(ADC_W'($urandom_range(ADC_MAX)), $urandom_range(99) < pin_pct);
          end
        end else begin
          mean = anchors[$urandom_range(3)] + $urandom_range(4) - 2;
          if (mean < 0) mean = 0;
          if (mean > ADC_MAX) mean = ADC_MAX;
          send_block(mean, pin_pct);
        end
      end
      drain();
    end
    steady = 1'b0;
  endtask

  // sequence
  initial begin
    rst_n = 1'b0;
    steady = 1'b0;
    faults = 0;
    items_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.bat_sample = '0;
    in_ch.mains_pin_low = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_scale();
    test_watchdog_edges();
    test_random_phases();

    drain();
    if (pending_ticks.size() != 0) begin
      report_fault($sformatf("%0d results never arrived", pending_ticks.size()));
    end
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
